/* rtl/core/rbb_pkg.sv */
// Shared types, sizes and codes of the run blob bounding box block.
package rbb_pkg;

  localparam int ColW     = 10;
  localparam int CfgW     = 11;
  localparam int MaxRuns  = 64;
  localparam int MaxRects = 256;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int RunIdxW  = $clog2(MaxRuns);
  localparam int RunCntW  = RunIdxW + 1;
  localparam int RectIdxW = $clog2(MaxRects);
  localparam int RectCntW = RectIdxW + 1;
  localparam int RunAddrW = RunIdxW + 1;

  localparam logic [1:0] ActPixel = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [1:0] CfgImageWidth  = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgMinRunSpan  = 2'd2;

  typedef struct packed {
    logic [ColW-1:0]     b;
    logic [ColW-1:0]     e;
    logic [RectIdxW-1:0] id;
  } run_t;

  typedef struct packed {
    logic [ColW-1:0] left;
    logic [ColW-1:0] top;
    logic [ColW-1:0] right;
    logic [ColW-1:0] bottom;
    logic            removed;
  } rect_t;

  typedef struct packed {
    logic            close;
    logic [ColW-1:0] b;
    logic [ColW-1:0] e;
    logic [ColW-1:0] row;
    logic            rowend;
  } scan_evt_t;

endpackage

/* rtl/core/rbb_if.sv */
// Request and response channel interfaces of the run blob bounding box block.
interface rbb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       pixel_on;
  logic [7:0] rect_index;
  modport source (output valid, action, pixel_on, rect_index, input ready);
  modport sink (input valid, action, pixel_on, rect_index, output ready);
endinterface

interface rbb_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] rect_left;
  logic [9:0] rect_top;
  logic [9:0] rect_right;
  logic [9:0] rect_bottom;
  logic       rect_removed;
  logic [8:0] rect_total;
  logic       frame_done;
  logic       overflow;
  modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, rect_removed,
                  rect_total, frame_done, overflow, input ready);
  modport sink (input valid, rect_left, rect_top, rect_right, rect_bottom, rect_removed,
                rect_total, frame_done, overflow, output ready);
endinterface

/* rtl/core/rbb_ram.sv */
// Generic single write port RAM with registered read.
module rbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/rbb_scan.sv */
// Raster position and run tracking of the pixel stream.
module rbb_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     clear_i,
  input  logic                     pixel_on_i,
  input  logic [rbb_pkg::CfgW-1:0] width_i,
  input  logic [rbb_pkg::CfgW-1:0] height_i,
  output rbb_pkg::scan_evt_t       evt_o,
  output logic                     done_o
);

  logic [rbb_pkg::ColW-1:0] col_q, col_d, row_q, row_d, begin_q, begin_d;
  logic                     open_q, open_d, done_q, done_d;
  logic [rbb_pkg::CfgW-1:0] wlim, hlim;
  logic                     last;

  always_comb begin
    if (width_i == '0) begin
      wlim = rbb_pkg::CfgW'(1);
    end else if (width_i > rbb_pkg::CfgW'(rbb_pkg::MaxWidth)) begin
      wlim = rbb_pkg::CfgW'(rbb_pkg::MaxWidth);
    end else begin
      wlim = width_i;
    end
    if (height_i == '0) begin
      hlim = rbb_pkg::CfgW'(1);
    end else if (height_i > rbb_pkg::CfgW'(rbb_pkg::MaxHeight)) begin
      hlim = rbb_pkg::CfgW'(rbb_pkg::MaxHeight);
    end else begin
      hlim = height_i;
    end
  end

  assign last = {1'b0, col_q} >= (wlim - rbb_pkg::CfgW'(1));

  always_comb begin
    evt_o.close  = open_q && (!pixel_on_i || last);
    evt_o.b      = begin_q;
    evt_o.e      = col_q;
    evt_o.row    = row_q;
    evt_o.rowend = last;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    begin_d = begin_q;
    open_d  = open_q;
    done_d  = done_q;
    if (clear_i) begin
      col_d   = '0;
      row_d   = '0;
      begin_d = '0;
      open_d  = 1'b0;
      done_d  = 1'b0;
    end else if (step_i) begin
      if (open_q) begin
        if (!pixel_on_i || last) begin
          open_d = 1'b0;
        end
      end else if (pixel_on_i && !last) begin
        open_d  = 1'b1;
        begin_d = col_q;
      end
      if (!last) begin
        col_d = col_q + rbb_pkg::ColW'(1);
      end else begin
        col_d  = '0;
        open_d = 1'b0;
        if (({1'b0, row_q} + rbb_pkg::CfgW'(1)) >= hlim) begin
          done_d = 1'b1;
        end else begin
          row_d = row_q + rbb_pkg::ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      begin_q <= '0;
      open_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      begin_q <= begin_d;
      open_q  <= open_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

/* rtl/core/run_blob_bounding_boxes.sv */
// Top level: request sequencer, run matching and rectangle table.
// A pixel without a kept run, a clear or any other action responds through S_FIN; a read through S_READ.
// A kept run walks the previous-row runs (S_SRD, S_SCHK per run), then updates the matched
// rectangle and its neighbor or opens a new one, writes the run (S_PUSH) and responds (S_FIN).
// One request at a time; the next is taken once the response is delivered.
// Reset: asynchronous, clears position, counts and flags; no memory sweep.
module run_blob_bounding_boxes (
  input  logic           clk_i,
  input  logic           rst_ni,
  rbb_req_if.sink        req,
  rbb_rsp_if.source      rsp,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [10:0]    cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCHK = 4'd2;
  localparam logic [3:0] S_RRD  = 4'd3;
  localparam logic [3:0] S_RUPD = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_NCHK = 4'd6;
  localparam logic [3:0] S_KRD  = 4'd7;
  localparam logic [3:0] S_KUPD = 4'd8;
  localparam logic [3:0] S_KWR  = 4'd9;
  localparam logic [3:0] S_NEW  = 4'd10;
  localparam logic [3:0] S_PUSH = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_READ = 4'd13;

  localparam int ColW = rbb_pkg::ColW;
  localparam int RunCntW = rbb_pkg::RunCntW;
  localparam int RectIdxW = rbb_pkg::RectIdxW;
  localparam int RectCntW = rbb_pkg::RectCntW;

  logic [3:0] state_q, state_d;
  logic [rbb_pkg::CfgW-1:0] width_q, height_q;
  logic [ColW-1:0] span_q;
  logic [ColW-1:0] wb_q, wb_d, we_q, we_d, wrow_q, wrow_d;
  logic rowend_q, rowend_d, rdhit_q, rdhit_d, ovf_q, ovf_d, bank_q, bank_d;
  logic [RunCntW-1:0] j_q, j_d, jn, prev_cnt_q, prev_cnt_d, curr_cnt_q, curr_cnt_d;
  logic [RectCntW-1:0] rcnt_q, rcnt_d;
  logic [RectIdxW-1:0] hit_q, hit_d, kid_q, kid_d;
  rbb_pkg::rect_t r_q, r_d, k_q, k_d, rect_rdata, rect_wdata, rupd, kupd;
  rbb_pkg::run_t run_rdata, run_wdata;
  logic rect_we, run_we;
  logic [RectIdxW-1:0] rect_waddr, rect_raddr;
  logic [rbb_pkg::RunAddrW-1:0] run_waddr, run_raddr;
  rbb_pkg::scan_evt_t evt;
  logic done, accept, step, clear;
  logic out_valid_q, out_valid_d;
  rbb_pkg::rect_t out_rect_q, out_rect_d;

  assign req.ready = (state_q == S_IDLE) && !out_valid_q;
  assign accept = req.valid && req.ready;
  assign step = accept && (req.action == rbb_pkg::ActPixel) && !done;
  assign clear = accept && (req.action == rbb_pkg::ActClear);
  assign jn = j_q + RunCntW'(1);

  rbb_scan u_scan (
    .clk_i,
    .rst_ni,
    .step_i     (step),
    .clear_i    (clear),
    .pixel_on_i (req.pixel_on),
    .width_i    (width_q),
    .height_i   (height_q),
    .evt_o      (evt),
    .done_o     (done)
  );

  rbb_ram #(.Width($bits(rbb_pkg::run_t)), .Depth(2 * rbb_pkg::MaxRuns)) u_run_ram (
    .clk_i,
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i (run_raddr),
    .rdata_o (run_rdata)
  );

  rbb_ram #(.Width($bits(rbb_pkg::rect_t)), .Depth(rbb_pkg::MaxRects)) u_rect_ram (
    .clk_i,
    .we_i    (rect_we),
    .waddr_i (rect_waddr),
    .wdata_i (rect_wdata),
    .raddr_i (rect_raddr),
    .rdata_o (rect_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbb_pkg::CfgW'(640);
      height_q <= rbb_pkg::CfgW'(480);
      span_q   <= ColW'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbb_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
        rbb_pkg::CfgImageHeight: height_q <= cfg_data_i;
        rbb_pkg::CfgMinRunSpan:  span_q   <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  // Merge of the run into its rectangle, and of the neighbor rectangle.
  always_comb begin
    rupd = rect_rdata;
    rupd.bottom = wrow_q;
    if (wb_q < rect_rdata.left) rupd.left = wb_q;
    if (we_q > rect_rdata.right) rupd.right = we_q;
    kupd = r_q;
    if (!rect_rdata.removed && (r_q.removed || rect_rdata.top < r_q.top)) begin
      kupd.top = rect_rdata.top;
      kupd.removed = 1'b0;
    end
    if (rect_rdata.left < r_q.left) kupd.left = rect_rdata.left;
    if (rect_rdata.right > r_q.right) kupd.right = rect_rdata.right;
  end

  always_comb begin
    state_d     = state_q;
    wb_d        = wb_q;
    we_d        = we_q;
    wrow_d      = wrow_q;
    rowend_d    = rowend_q;
    rdhit_d     = rdhit_q;
    ovf_d       = ovf_q;
    bank_d      = bank_q;
    j_d         = j_q;
    prev_cnt_d  = prev_cnt_q;
    curr_cnt_d  = curr_cnt_q;
    rcnt_d      = rcnt_q;
    hit_d       = hit_q;
    kid_d       = kid_q;
    r_d         = r_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_rect_d  = out_rect_q;
    rect_we     = 1'b0;
    rect_waddr  = hit_q;
    rect_wdata  = rupd;
    rect_raddr  = hit_q;
    run_we      = 1'b0;
    run_waddr   = {~bank_q, curr_cnt_q[rbb_pkg::RunIdxW-1:0]};
    run_wdata   = '{b: wb_q, e: we_q, id: hit_q};
    run_raddr   = {bank_q, j_q[rbb_pkg::RunIdxW-1:0]};
    if (out_valid_q && rsp.ready) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        rect_raddr = req.rect_index;
        if (accept) begin
          rowend_d = 1'b0;
          state_d  = S_FIN;
          case (req.action)
            rbb_pkg::ActPixel: begin
              if (!done) begin
                wb_d     = evt.b;
                we_d     = evt.e;
                wrow_d   = evt.row;
                rowend_d = evt.rowend;
                if (evt.close && ((evt.e - evt.b) > span_q)) begin
                  if (curr_cnt_q >= RunCntW'(rbb_pkg::MaxRuns)) begin
                    ovf_d = 1'b1;
                  end else begin
                    j_d     = '0;
                    state_d = S_SRD;
                  end
                end
              end
            end
            rbb_pkg::ActRead: begin
              rdhit_d = {1'b0, req.rect_index} < rcnt_q;
              state_d = S_READ;
            end
            rbb_pkg::ActClear: begin
              prev_cnt_d = '0;
              curr_cnt_d = '0;
              rcnt_d     = '0;
              ovf_d      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SRD: begin
        state_d = (j_q >= prev_cnt_q) ? S_NEW : S_SCHK;
      end
      S_SCHK: begin
        if (run_rdata.b <= we_q && wb_q <= run_rdata.e) begin
          hit_d   = run_rdata.id;
          state_d = S_RRD;
        end else begin
          j_d     = jn;
          state_d = S_SRD;
        end
      end
      S_RRD: begin
        state_d = S_RUPD;
      end
      S_RUPD: begin
        rect_we = 1'b1;
        r_d     = rupd;
        state_d = (jn < prev_cnt_q) ? S_NRD : S_PUSH;
      end
      S_NRD: begin
        run_raddr = {bank_q, jn[rbb_pkg::RunIdxW-1:0]};
        state_d   = S_NCHK;
      end
      S_NCHK: begin
        if ({1'b0, run_rdata.b} <= ({1'b0, we_q} + (ColW+1)'(1)) &&
            {1'b0, wb_q} <= ({1'b0, run_rdata.e} + (ColW+1)'(1))) begin
          kid_d   = run_rdata.id;
          state_d = S_KRD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_KRD: begin
        rect_raddr = kid_q;
        state_d    = S_KUPD;
      end
      S_KUPD: begin
        rect_we    = 1'b1;
        rect_wdata = kupd;
        k_d        = rect_rdata;
        state_d    = (kid_q != hit_q) ? S_KWR : S_PUSH;
      end
      S_KWR: begin
        rect_we    = 1'b1;
        rect_waddr = kid_q;
        rect_wdata = '{left: k_q.left, top: k_q.top, right: k_q.right,
                       bottom: k_q.bottom, removed: 1'b1};
        state_d    = S_PUSH;
      end
      S_NEW: begin
        if (rcnt_q >= RectCntW'(rbb_pkg::MaxRects)) begin
          ovf_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          rect_we    = 1'b1;
          rect_waddr = rcnt_q[RectIdxW-1:0];
          rect_wdata = '{left: wb_q, top: wrow_q, right: we_q, bottom: wrow_q,
                         removed: 1'b0};
          hit_d      = rcnt_q[RectIdxW-1:0];
          rcnt_d     = rcnt_q + RectCntW'(1);
          state_d    = S_PUSH;
        end
      end
      S_PUSH: begin
        run_we     = 1'b1;
        curr_cnt_d = curr_cnt_q + RunCntW'(1);
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (rowend_q) begin
          bank_d     = ~bank_q;
          prev_cnt_d = curr_cnt_q;
          curr_cnt_d = '0;
        end
        out_rect_d  = '0;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        out_rect_d  = rdhit_q ? rect_rdata : '0;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rowend_q    <= 1'b0;
      rdhit_q     <= 1'b0;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      j_q         <= '0;
      prev_cnt_q  <= '0;
      curr_cnt_q  <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rowend_q    <= rowend_d;
      rdhit_q     <= rdhit_d;
      ovf_q       <= ovf_d;
      bank_q      <= bank_d;
      j_q         <= j_d;
      prev_cnt_q  <= prev_cnt_d;
      curr_cnt_q  <= curr_cnt_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q       <= wb_d;
    we_q       <= we_d;
    wrow_q     <= wrow_d;
    hit_q      <= hit_d;
    kid_q      <= kid_d;
    r_q        <= r_d;
    k_q        <= k_d;
    out_rect_q <= out_rect_d;
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.rect_left    = out_rect_q.left;
  assign rsp.rect_top     = out_rect_q.top;
  assign rsp.rect_right   = out_rect_q.right;
  assign rsp.rect_bottom  = out_rect_q.bottom;
  assign rsp.rect_removed = out_rect_q.removed;
  assign rsp.rect_total   = rcnt_q;
  assign rsp.frame_done   = done;
  assign rsp.overflow     = ovf_q;

  a_curr_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    curr_cnt_q <= RunCntW'(rbb_pkg::MaxRuns))
    else $error("current run count beyond capacity");

  a_rect_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RectCntW'(rbb_pkg::MaxRects))
    else $error("rectangle count beyond capacity");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready)
    else $error("request taken while busy");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |=> (curr_cnt_q == $past(curr_cnt_q) + RunCntW'(1)))
    else $error("run push did not advance the count");

endmodule

/* tb/tb_run_blob_bounding_boxes.sv */
// Self-checking testbench of the run blob bounding box block: random and directed pixel streams.
`timescale 1ns / 100ps

module tb_run_blob_bounding_boxes;

  localparam logic [1:0] ActIgnored = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic       pixel_on;
    logic [7:0] rect_index;
  } request_t;

  typedef struct packed {
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] right;
    logic [9:0] bottom;
    logic       removed;
    logic [8:0] total;
    logic       done;
    logic       ovf;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = rbb_pkg::CfgImageWidth;
  logic [10:0] cfg_data_i = '0;

  rbb_req_if req ();
  rbb_rsp_if rsp ();

  run_blob_bounding_boxes u_top (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  request_t pending_q[$];
  status_t  status_q[$];
  request_t cur_req;
  bit req_taken = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int requests_done = 0;
  int reads_done = 0;
  int cfg_writes = 0;

  // block model state
  int unsigned img_w, img_h, min_span;
  int unsigned col, row, run_begin, prev_cnt, curr_cnt, rect_cnt;
  bit run_open, ovf_flag, frame_done;
  int prev_b[rbb_pkg::MaxRuns], prev_e[rbb_pkg::MaxRuns], prev_id[rbb_pkg::MaxRuns];
  int curr_b[rbb_pkg::MaxRuns], curr_e[rbb_pkg::MaxRuns], curr_id[rbb_pkg::MaxRuns];
  int unsigned box_l[rbb_pkg::MaxRects], box_t_[rbb_pkg::MaxRects];
  int unsigned box_r[rbb_pkg::MaxRects], box_bt[rbb_pkg::MaxRects];
  bit box_rm[rbb_pkg::MaxRects];

  function automatic void clear_frame();
    col = 0; row = 0; run_open = 0; run_begin = 0;
    prev_cnt = 0; curr_cnt = 0; rect_cnt = 0; ovf_flag = 0; frame_done = 0;
  endfunction

  function automatic void close_run(int b, int e);
    int j;
    int id;
    int kid;
    bit hit;
    if (e - b <= min_span) return;
    if (curr_cnt >= rbb_pkg::MaxRuns) begin
      ovf_flag = 1;
      return;
    end
    hit = 0;
    for (j = 0; j < prev_cnt; j++) begin
      if ((b > prev_b[j] ? b : prev_b[j]) <= (e < prev_e[j] ? e : prev_e[j])) begin
        hit = 1;
        break;
      end
    end
    if (hit) begin
      id = prev_id[j];
      box_bt[id] = row;
      if (b < box_l[id]) box_l[id] = b;
      if (e > box_r[id]) box_r[id] = e;
      if (j + 1 < prev_cnt) begin
        if ((b > prev_b[j+1] - 1 ? b : prev_b[j+1] - 1) <=
            (e < prev_e[j+1] + 1 ? e : prev_e[j+1] + 1)) begin
          kid = prev_id[j+1];
          if (!box_rm[kid] && (box_rm[id] || box_t_[kid] < box_t_[id])) begin
            box_t_[id] = box_t_[kid];
            box_rm[id] = 0;
          end
          if (box_l[kid] < box_l[id]) box_l[id] = box_l[kid];
          if (box_r[kid] > box_r[id]) box_r[id] = box_r[kid];
          if (kid != id) box_rm[kid] = 1;
        end
      end
    end else begin
      if (rect_cnt >= rbb_pkg::MaxRects) begin
        ovf_flag = 1;
        return;
      end
      id = rect_cnt++;
      box_l[id] = b; box_r[id] = e; box_t_[id] = row; box_bt[id] = row; box_rm[id] = 0;
    end
    curr_b[curr_cnt] = b; curr_e[curr_cnt] = e; curr_id[curr_cnt] = id;
    curr_cnt++;
  endfunction

  function automatic void take_pixel(bit on);
    int unsigned w;
    int unsigned h;
    bit last;
    w = img_w < 1 ? 1 : (img_w > rbb_pkg::MaxWidth ? rbb_pkg::MaxWidth : img_w);
    h = img_h < 1 ? 1 : (img_h > rbb_pkg::MaxHeight ? rbb_pkg::MaxHeight : img_h);
    last = col >= w - 1;
    if (run_open) begin
      if (!on || last) begin
        close_run(run_begin, col);
        run_open = 0;
      end
    end else if (on && !last) begin
      run_open = 1;
      run_begin = col;
    end
    if (!last) begin
      col++;
      return;
    end
    for (int i = 0; i < curr_cnt; i++) begin
      prev_b[i] = curr_b[i]; prev_e[i] = curr_e[i]; prev_id[i] = curr_id[i];
    end
    prev_cnt = curr_cnt;
    curr_cnt = 0;
    col = 0;
    run_open = 0;
    if (row + 1 >= h) frame_done = 1;
    else row++;
  endfunction

  function automatic status_t predict_status(request_t r);
    status_t s;
    s = '0;
    case (r.action)
      rbb_pkg::ActPixel: if (!frame_done) take_pixel(r.pixel_on);
      rbb_pkg::ActRead: begin
        if (r.rect_index < rect_cnt) begin
          s.left = 10'(box_l[r.rect_index]); s.top = 10'(box_t_[r.rect_index]);
          s.right = 10'(box_r[r.rect_index]); s.bottom = 10'(box_bt[r.rect_index]);
          s.removed = box_rm[r.rect_index];
        end
      end
      rbb_pkg::ActClear: clear_frame();
      default: ;
    endcase
    s.total = rect_cnt[8:0];
    s.done = frame_done;
    s.ovf = ovf_flag;
    return s;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      req_taken = 0;
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req = pending_q.pop_front();
        req.action <= cur_req.action;
        req.pixel_on <= cur_req.pixel_on;
        req.rect_index <= cur_req.rect_index;
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
    rsp.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    req.valid = 1'b0;
    req.action = rbb_pkg::ActPixel;
    req.pixel_on = 1'b0;
    req.rect_index = '0;
    rsp.ready = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.rect_left, rsp.rect_top, rsp.rect_right, rsp.rect_bottom,
              rsp.rect_removed, rsp.rect_total, rsp.frame_done, rsp.overflow};
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (rst_ni && req.valid && req.ready) begin
      req_taken = 1;
      requests_done++;
      if (req.action == rbb_pkg::ActRead) reads_done++;
      status_q.insert(status_q.size(),
                      predict_status('{req.action, req.pixel_on, req.rect_index}));
    end
  end

  task automatic push(logic [1:0] a, logic p, logic [7:0] idx);
    pending_q.insert(pending_q.size(), '{a, p, idx});
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || req.valid || status_q.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [10:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = data;
    case (idx)
      rbb_pkg::CfgImageWidth:  img_w = data;
      rbb_pkg::CfgImageHeight: img_h = data;
      rbb_pkg::CfgMinRunSpan:  min_span = data[9:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic striped_row(int w);
    for (int c = 0; c < w; c++) push(rbb_pkg::ActPixel, (c % 2) == 0, 8'($urandom));
  endtask

  task automatic random_frame(int w, int h);
    logic [63:0] line;
    line = {$urandom, $urandom};
    for (int y = 0; y < h; y++) begin
      for (int c = 0; c < w; c++) if ($urandom_range(0, 5) == 0) line[c] = ~line[c];
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 14) == 0) begin
          push(rbb_pkg::ActRead, 1'($urandom), 8'($urandom_range(0, 12)));
        end
        if ($urandom_range(0, 59) == 0) push(ActIgnored, 1'($urandom), 8'($urandom));
        push(rbb_pkg::ActPixel, line[c], 8'($urandom));
      end
    end
    for (int i = 0; i < 8; i++) push(rbb_pkg::ActRead, 1'($urandom), 8'(i));
    push(rbb_pkg::ActRead, 1'($urandom), 8'($urandom));
    push(rbb_pkg::ActPixel, 1'($urandom), 8'($urandom));
  endtask

  initial begin
    img_w = 640; img_h = 480; min_span = 2;
    clear_frame();
    send_idle_pct = 8; recv_stall_pct = 51;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    write_cfg(rbb_pkg::CfgImageWidth, 11'd4);
    write_cfg(rbb_pkg::CfgImageHeight, 11'd2);
    write_cfg(rbb_pkg::CfgMinRunSpan, 11'd0);
    push(rbb_pkg::ActClear, 1'b1, 8'hff);
    push(rbb_pkg::ActPixel, 1, 0); push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActPixel, 1, 0); push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActPixel, 0, 0); push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActPixel, 0, 0); push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActRead, 0, 0); push(rbb_pkg::ActRead, 1, 1);
    push(rbb_pkg::ActRead, 0, 8'hff);
    push(ActIgnored, 1, 8'hff);
    push(rbb_pkg::ActClear, 0, 0);
    push(rbb_pkg::ActPixel, 0, 0); push(rbb_pkg::ActPixel, 0, 0);
    push(rbb_pkg::ActPixel, 0, 0); push(rbb_pkg::ActPixel, 1, 0);
    push(rbb_pkg::ActRead, 0, 0);
    drain();

    // fill the rectangle table, blank rows in between
    write_cfg(rbb_pkg::CfgImageHeight, 11'd2047);
    push(rbb_pkg::ActClear, 0, 0);
    drain();
    for (int k = 0; k < 4; k++) begin
      write_cfg(rbb_pkg::CfgImageWidth, 11'd128);
      striped_row(128);
      drain();
      write_cfg(rbb_pkg::CfgImageWidth, 11'd1);
      push(rbb_pkg::ActPixel, 0, 0);
      drain();
    end
    write_cfg(rbb_pkg::CfgImageWidth, 11'd8);
    striped_row(8);
    for (int i = 0; i < 4; i++) push(rbb_pkg::ActRead, 1, 8'($urandom));
    push(rbb_pkg::ActRead, 1, 8'hff);
    drain();
    // too many runs in one row
    write_cfg(rbb_pkg::CfgImageWidth, 11'd132);
    push(rbb_pkg::ActClear, 0, 0);
    striped_row(132);
    push(rbb_pkg::ActRead, 0, 64);
    drain();

    // zero width setting, highest span
    write_cfg(rbb_pkg::CfgImageWidth, 11'd0);
    write_cfg(rbb_pkg::CfgImageHeight, 11'd3);
    write_cfg(rbb_pkg::CfgMinRunSpan, 11'd1023);
    push(rbb_pkg::ActClear, 0, 0);
    for (int c = 0; c < 5; c++) push(rbb_pkg::ActPixel, 1, 8'($urandom));
    push(rbb_pkg::ActRead, 0, 0);
    drain();

    write_cfg(rbb_pkg::CfgImageHeight, 11'd1024);
    write_cfg(rbb_pkg::CfgMinRunSpan, 11'd0);
    send_idle_pct = 51; recv_stall_pct = 8;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      write_cfg(rbb_pkg::CfgImageWidth, 11'($urandom_range(6, 40)));
      write_cfg(rbb_pkg::CfgImageHeight, 11'($urandom_range(2, 8)));
      write_cfg(rbb_pkg::CfgMinRunSpan, 11'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) push(rbb_pkg::ActClear, 1'($urandom), 8'($urandom));
      random_frame(img_w, img_h);
      drain();
    end

    drain();
    repeat (30) @(negedge clk_i);
    $display("Covered %0d requests (%0d rectangle reads) over %0d register writes.",
             requests_done, reads_done, cfg_writes);
    $display("Mismatches: %0d, responses still owed: %0d", mismatches, status_q.size());
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout waiting for the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
